>>> design/vru_pkg.sv
// ----------------------------------------------------------------------------
// vru_pkg
// Shared widths and types for the vector refraction pipeline.
// ----------------------------------------------------------------------------
package vru_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int AXES          = 3;
    localparam int VEC_W         = 32;
    localparam int NRM_W         = 18;
    localparam int RATIO_W       = 19;

    typedef logic [AXES-1:0][VEC_W-1:0] t_vec;

    // surface normal and index ratio, carried alongside the incident vector
    typedef struct packed {
        logic [AXES-1:0][NRM_W-1:0] normal;
        logic [RATIO_W-1:0]         ratio;
    } t_geom;

endpackage

>>> design/vru_isqrt.sv
// ----------------------------------------------------------------------------
// vru_isqrt
// Pipelined integer square root, one root bit per stage, with side payload.
// ----------------------------------------------------------------------------
module vru_isqrt #(
    parameter int RAD_W  = 64,
    parameter int SIDE_W = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [RAD_W-1:0]    i_rad,
    input  logic [SIDE_W-1:0]   i_side,
    output logic                o_valid,
    output logic [RAD_W/2-1:0]  o_root,
    output logic [SIDE_W-1:0]   o_side
);

    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 3;

    logic [ROOT_W-1:0]  r_vld;
    logic [RAD_W-1:0]   r_rad  [ROOT_W];
    logic [REM_W-1:0]   r_rem  [ROOT_W];
    logic [ROOT_W-1:0]  r_root [ROOT_W];
    logic [SIDE_W-1:0]  r_side [ROOT_W];

    for (genvar j = 0; j < ROOT_W; j++) begin : g_step
        logic              w_vld;
        logic [RAD_W-1:0]  w_rad;
        logic [REM_W-1:0]  w_rem;
        logic [ROOT_W-1:0] w_root;
        logic [SIDE_W-1:0] w_side;
        logic [REM_W-1:0]  w_acc;
        logic [REM_W-1:0]  w_trial;
        logic              w_ge;

        if (j == 0) begin : g_head
            assign w_vld  = i_valid;
            assign w_rad  = i_rad;
            assign w_rem  = '0;
            assign w_root = '0;
            assign w_side = i_side;
        end else begin : g_body
            assign w_vld  = r_vld[j-1];
            assign w_rad  = r_rad[j-1];
            assign w_rem  = r_rem[j-1];
            assign w_root = r_root[j-1];
            assign w_side = r_side[j-1];
        end

        // bring down the next bit pair and try root*4+1
        assign w_acc   = {w_rem[REM_W-3:0], w_rad[RAD_W-1-2*j -: 2]};
        assign w_trial = REM_W'({w_root, 2'b01});
        assign w_ge    = (w_acc >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[j]  <= w_rad;
                r_rem[j]  <= w_ge ? (w_acc - w_trial) : w_acc;
                r_root[j] <= {w_root[ROOT_W-2:0], w_ge};
                r_side[j] <= w_side;
            end
        end
    end

    assign o_valid = r_vld[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];

endmodule

>>> design/vru_div.sv
// ----------------------------------------------------------------------------
// vru_div
// Pipelined restoring divider, one quotient bit per stage, several lanes
// sharing one divisor. The numerator must stay below divisor * 2^QUO_W.
// ----------------------------------------------------------------------------
module vru_div #(
    parameter int LANES  = 3,
    parameter int DEN_W  = 32,
    parameter int QUO_W  = 17,
    parameter int SIDE_W = 1
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  logic [LANES-1:0][DEN_W+QUO_W-1:0]     i_num,
    input  logic [DEN_W-1:0]                      i_den,
    input  logic [SIDE_W-1:0]                     i_side,
    output logic                                  o_valid,
    output logic [LANES-1:0][QUO_W-1:0]           o_quo,
    output logic [SIDE_W-1:0]                     o_side
);

    localparam int NUM_W = DEN_W + QUO_W;

    logic [QUO_W-1:0]                   r_vld;
    logic [LANES-1:0][DEN_W-1:0]        r_rem  [QUO_W];
    logic [LANES-1:0][QUO_W-1:0]        r_low  [QUO_W];
    logic [LANES-1:0][QUO_W-1:0]        r_quo  [QUO_W];
    logic [DEN_W-1:0]                   r_den  [QUO_W];
    logic [SIDE_W-1:0]                  r_side [QUO_W];

    for (genvar j = 0; j < QUO_W; j++) begin : g_step
        logic                         w_vld;
        logic [LANES-1:0][DEN_W-1:0]  w_rem;
        logic [LANES-1:0][QUO_W-1:0]  w_low;
        logic [LANES-1:0][QUO_W-1:0]  w_quo;
        logic [DEN_W-1:0]             w_den;
        logic [SIDE_W-1:0]            w_side;
        logic [LANES-1:0][DEN_W:0]    w_acc;
        logic [LANES-1:0][DEN_W-1:0]  n_rem;
        logic [LANES-1:0][QUO_W-1:0]  n_quo;

        if (j == 0) begin : g_head
            assign w_vld  = i_valid;
            assign w_den  = i_den;
            assign w_side = i_side;
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    w_rem[l] = i_num[l][NUM_W-1:QUO_W];
                    w_low[l] = i_num[l][QUO_W-1:0];
                    w_quo[l] = '0;
                end
            end
        end else begin : g_body
            assign w_vld  = r_vld[j-1];
            assign w_rem  = r_rem[j-1];
            assign w_low  = r_low[j-1];
            assign w_quo  = r_quo[j-1];
            assign w_den  = r_den[j-1];
            assign w_side = r_side[j-1];
        end

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                w_acc[l] = {w_rem[l], w_low[l][QUO_W-1]};
                if (w_acc[l] >= {1'b0, w_den}) begin
                    n_rem[l] = DEN_W'(w_acc[l] - {1'b0, w_den});
                    n_quo[l] = {w_quo[l][QUO_W-2:0], 1'b1};
                end else begin
                    n_rem[l] = w_acc[l][DEN_W-1:0];
                    n_quo[l] = {w_quo[l][QUO_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]  <= n_rem;
                r_quo[j]  <= n_quo;
                r_den[j]  <= w_den;
                r_side[j] <= w_side;
                for (int l = 0; l < LANES; l++) begin
                    r_low[j][l] <= {w_low[l][QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_vld[QUO_W-1];
    assign o_quo   = r_quo[QUO_W-1];
    assign o_side  = r_side[QUO_W-1];

endmodule

>>> design/vru_norm.sv
// ----------------------------------------------------------------------------
// vru_norm
// Incident vector normalization: prescale, sum of squares, root, divide.
// ----------------------------------------------------------------------------
module vru_norm #(
    parameter int FRAC_BITS = vru_pkg::FRAC_BITS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_en,
    input  logic                                     i_valid,
    input  vru_pkg::t_vec                            i_vec,
    input  vru_pkg::t_geom                           i_geom,
    output logic                                     o_valid,
    output logic [vru_pkg::AXES-1:0][FRAC_BITS+1:0]  o_unit,
    output vru_pkg::t_geom                           o_geom
);

    localparam int AX       = vru_pkg::AXES;
    localparam int VW       = vru_pkg::VEC_W;
    localparam int SQ_W     = 2 * VW;
    localparam int QUO_W    = FRAC_BITS + 1;
    localparam int NUM_W    = VW + QUO_W;
    localparam int UW       = FRAC_BITS + 2;
    localparam int SH_W     = $clog2(VW);
    localparam int NORM_BIT = VW - 3;

    typedef struct packed {
        logic [AX-1:0][VW-1:0] mag;
        logic [AX-1:0]         neg;
        logic                  zero;
        vru_pkg::t_geom        geom;
    } t_root_side;

    typedef struct packed {
        logic [AX-1:0]         neg;
        logic                  zero;
        vru_pkg::t_geom        geom;
    } t_div_side;

    // stage 1: magnitudes and prescale amount
    logic [AX-1:0][VW-1:0] w_abs;
    logic [VW-1:0]         w_max;
    logic [SH_W-1:0]       w_hb;
    logic [SH_W-1:0]       w_sh;

    always_comb begin
        w_max = '0;
        w_hb  = '0;
        for (int a = 0; a < AX; a++) begin
            w_abs[a] = i_vec[a][VW-1] ? (~i_vec[a] + 1'b1) : i_vec[a];
            if (w_abs[a] > w_max) begin
                w_max = w_abs[a];
            end
        end
        for (int b = 0; b < VW; b++) begin
            if (w_max[b]) begin
                w_hb = SH_W'(b);
            end
        end
        w_sh = (w_hb >= SH_W'(NORM_BIT)) ? '0 : SH_W'(NORM_BIT) - w_hb;
    end

    logic                  r1_vld, r2_vld, r3_vld, r4_vld, r5_vld, r6_vld;
    logic [AX-1:0][VW-1:0] r1_abs, r2_mag, r3_mag, r4_mag;
    logic [AX-1:0][SQ_W-1:0] r3_sq;
    logic [SQ_W-1:0]       r4_sum;
    logic [AX-1:0]         r1_neg, r2_neg, r3_neg, r4_neg;
    logic                  r1_zero, r2_zero, r3_zero, r4_zero;
    logic [SH_W-1:0]       r1_sh;
    vru_pkg::t_geom        r1_geom, r2_geom, r3_geom, r4_geom, r6_geom;
    logic [AX-1:0][NUM_W-1:0] r5_num;
    logic [VW-1:0]         r5_len;
    t_div_side             r5_side;
    logic [AX-1:0][UW-1:0] r6_unit;

    t_root_side            w_root_in, w_root_out;
    logic                  w_root_vld;
    logic [VW-1:0]         w_len;
    t_div_side             w_div_out;
    logic                  w_div_vld;
    logic [AX-1:0][QUO_W-1:0] w_quo;
    logic [AX-1:0][NUM_W-1:0] n_num;
    logic [AX-1:0][UW-1:0] n_unit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= w_root_vld;
            r6_vld <= w_div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_abs  <= w_abs;
            r1_sh   <= w_sh;
            r1_zero <= (w_max == '0);
            r1_geom <= i_geom;
            for (int a = 0; a < AX; a++) begin
                r1_neg[a] <= i_vec[a][VW-1];
            end

            for (int a = 0; a < AX; a++) begin
                r2_mag[a] <= r1_abs[a] << r1_sh;
            end
            r2_neg  <= r1_neg;
            r2_zero <= r1_zero;
            r2_geom <= r1_geom;

            for (int a = 0; a < AX; a++) begin
                r3_sq[a] <= SQ_W'(r2_mag[a]) * SQ_W'(r2_mag[a]);
            end
            r3_mag  <= r2_mag;
            r3_neg  <= r2_neg;
            r3_zero <= r2_zero;
            r3_geom <= r2_geom;

            r4_sum  <= r3_sq[0] + r3_sq[1] + r3_sq[2];
            r4_mag  <= r3_mag;
            r4_neg  <= r3_neg;
            r4_zero <= r3_zero;
            r4_geom <= r3_geom;

            r5_num  <= n_num;
            r5_len  <= w_len;
            r5_side <= '{neg: w_root_out.neg, zero: w_root_out.zero,
                         geom: w_root_out.geom};

            r6_unit <= n_unit;
            r6_geom <= w_div_out.geom;
        end
    end

    assign w_root_in = '{mag: r4_mag, neg: r4_neg, zero: r4_zero, geom: r4_geom};

    vru_isqrt #(
        .RAD_W  (SQ_W),
        .SIDE_W ($bits(t_root_side))
    ) u_len_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r4_vld),
        .i_rad   (r4_sum),
        .i_side  (w_root_in),
        .o_valid (w_root_vld),
        .o_root  (w_len),
        .o_side  (w_root_out)
    );

    // round to nearest: add half the length before dividing
    always_comb begin
        for (int a = 0; a < AX; a++) begin
            n_num[a] = NUM_W'({w_root_out.mag[a], {FRAC_BITS{1'b0}}})
                     + NUM_W'(w_len[VW-1:1]);
        end
    end

    vru_div #(
        .LANES  (AX),
        .DEN_W  (VW),
        .QUO_W  (QUO_W),
        .SIDE_W ($bits(t_div_side))
    ) u_unit_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r5_vld),
        .i_num   (r5_num),
        .i_den   (r5_len),
        .i_side  (r5_side),
        .o_valid (w_div_vld),
        .o_quo   (w_quo),
        .o_side  (w_div_out)
    );

    // restore sign; a zero vector passes through as zero
    always_comb begin
        for (int a = 0; a < AX; a++) begin
            if (w_div_out.zero) begin
                n_unit[a] = '0;
            end else if (w_div_out.neg[a]) begin
                n_unit[a] = ~{1'b0, w_quo[a]} + 1'b1;
            end else begin
                n_unit[a] = {1'b0, w_quo[a]};
            end
        end
    end

    assign o_valid = r6_vld;
    assign o_unit  = r6_unit;
    assign o_geom  = r6_geom;

endmodule

>>> design/vru_snell.sv
// ----------------------------------------------------------------------------
// vru_snell
// Cosine, discriminant, root and refracted direction with saturation.
// ----------------------------------------------------------------------------
module vru_snell #(
    parameter int FRAC_BITS = vru_pkg::FRAC_BITS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_en,
    input  logic                                     i_valid,
    input  logic [vru_pkg::AXES-1:0][FRAC_BITS+1:0]  i_unit,
    input  vru_pkg::t_geom                           i_geom,
    output logic                                     o_valid,
    output vru_pkg::t_vec                            o_refr,
    output logic                                     o_did_refract,
    output logic                                     o_saturated
);

    localparam int F    = FRAC_BITS;
    localparam int AX   = vru_pkg::AXES;
    localparam int VW   = vru_pkg::VEC_W;
    localparam int NW   = vru_pkg::NRM_W;
    localparam int RW   = vru_pkg::RATIO_W;
    localparam int UW   = F + 2;
    localparam int P1W  = UW + NW;
    localparam int SW   = P1W + 2;
    localparam int CW   = F + 5;
    localparam int RRW  = 2 * RW;
    localparam int RRS  = RRW + 1;
    localparam int R2W  = RRS - F;
    localparam int CCP  = 2 * CW;
    localparam int CCS  = CCP + 1;
    localparam int CCW  = CCS - F;
    localparam int OMW  = ((CCW > F + 2) ? CCW : F + 2) + 1;
    localparam int KPW  = R2W + 1 + OMW;
    localparam int KPS  = KPW + 1;
    localparam int KMW  = KPS - F;
    localparam int KW   = ((KMW > F + 2) ? KMW : F + 2) + 1;
    localparam int SRW  = 2 * ((KW + F) / 2);
    localparam int SQW  = SRW / 2;
    localparam int NCP  = NW + CW;
    localparam int NCS  = NCP + 1;
    localparam int NCW  = NCS - F;
    localparam int TW   = ((UW > NCW) ? UW : NCW) + 1;
    localparam int RSW  = RW + 1;
    localparam int RTP  = RSW + TW;
    localparam int RTS  = RTP + 1;
    localparam int RTQ  = RTS - F;
    localparam int NSP  = NW + SQW + 1;
    localparam int NSS  = NSP + 1;
    localparam int NSQ  = NSS - F;
    localparam int ODW  = ((RTQ > NSQ) ? RTQ : NSQ) + 1;
    localparam int OCW  = (ODW > VW + 1) ? ODW : VW + 1;
    localparam int HALF = 1 << (F - 1);
    localparam int ONE  = 1 << F;

    localparam logic signed [OCW-1:0] POS_LIM = OCW'((64'sd1 <<< (VW - 1)) - 64'sd1);
    localparam logic signed [OCW-1:0] NEG_LIM = ~POS_LIM;

    typedef struct packed {
        logic                  tir;
        logic [AX-1:0][TW-1:0] t;
        vru_pkg::t_geom        geom;
    } t_root_side;

    logic r1_vld, r2_vld, r3_vld, r4_vld, r5_vld, r6_vld, r7_vld, r8_vld;

    logic signed [UW-1:0]   w_u  [AX];
    logic signed [UW-1:0]   r1_u [AX], r2_u [AX], r3_u [AX];
    logic signed [P1W-1:0]  r1_p [AX];
    vru_pkg::t_geom         r1_geom, r2_geom, r3_geom, r4_geom, r5_geom;
    logic signed [SW-1:0]   w_csum;
    logic signed [CW-1:0]   r2_c;
    logic [RRW-1:0]         r2_rr;
    logic signed [CCP-1:0]  r3_ccp;
    logic [RRS-1:0]         w_rrs;
    logic [R2W-1:0]         r3_r2, r4_r2;
    logic signed [NCP-1:0]  r3_ncp [AX];

    logic signed [CCS-1:0]  w_ccs;
    logic signed [CCW-1:0]  w_cc;
    logic signed [NCS-1:0]  w_ncs [AX];
    logic signed [NCW-1:0]  w_nc  [AX];
    logic signed [OMW-1:0]  r4_omc;
    logic signed [TW-1:0]   r4_t [AX], r5_t [AX];
    logic signed [R2W:0]    w_r2s;
    logic signed [KPW-1:0]  r5_kp;
    logic signed [KPS-1:0]  w_kps;
    logic signed [KMW-1:0]  w_km;
    logic signed [KW-1:0]   w_k;
    logic [SRW-1:0]         r6_rad;
    t_root_side             r6_side, w_root_out;
    logic                   w_root_vld;
    logic [SQW-1:0]         w_sq;

    logic signed [RSW-1:0]  w_rs;
    logic signed [NW-1:0]   w_fn [AX];
    logic signed [TW-1:0]   w_ft [AX];
    logic signed [SQW:0]    w_sqs;
    logic signed [RTP-1:0]  r7_rt  [AX];
    logic signed [NSP-1:0]  r7_nsq [AX];
    logic                   r7_tir;

    logic signed [RTS-1:0]  w_rts  [AX];
    logic signed [NSS-1:0]  w_nss  [AX];
    logic signed [RTQ-1:0]  w_rtq  [AX];
    logic signed [NSQ-1:0]  w_nsq  [AX];
    logic signed [OCW-1:0]  w_o    [AX];
    logic [AX-1:0][VW-1:0]  n_refr;
    logic [AX-1:0]          n_clip;
    vru_pkg::t_vec          r8_refr;
    logic                   r8_did;
    logic                   r8_sat;

    // per-axis views of the packed inputs
    always_comb begin
        for (int a = 0; a < AX; a++) begin
            w_u[a] = $signed(i_unit[a]);
        end
    end

    // rounding of the cosine sum and r^2
    always_comb begin
        w_csum = SW'(r1_p[0]) + SW'(r1_p[1]) + SW'(r1_p[2]) + SW'(HALF);
        w_rrs  = RRS'(r2_rr) + RRS'(HALF);
    end

    // 1 - c^2 and the tangential part u - n*c
    always_comb begin
        w_ccs = CCS'(r3_ccp) + CCS'(HALF);
        w_cc  = w_ccs[CCS-1:F];
        for (int a = 0; a < AX; a++) begin
            w_ncs[a] = NCS'(r3_ncp[a]) + NCS'(HALF);
            w_nc[a]  = w_ncs[a][NCS-1:F];
        end
        w_r2s = {1'b0, r4_r2};
    end

    // discriminant; a negative one flags total internal reflection
    always_comb begin
        w_kps = KPS'(r5_kp) + KPS'(HALF);
        w_km  = w_kps[KPS-1:F];
        w_k   = KW'(ONE) - KW'(w_km);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
            r8_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
            r7_vld <= w_root_vld;
            r8_vld <= r7_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int a = 0; a < AX; a++) begin
                r1_p[a] <= w_u[a] * $signed(i_geom.normal[a]);
                r1_u[a] <= w_u[a];
                r2_u[a] <= r1_u[a];
                r3_u[a] <= r2_u[a];
                r3_ncp[a] <= $signed(r2_geom.normal[a]) * r2_c;
                r4_t[a] <= TW'(r3_u[a]) - TW'(w_nc[a]);
                r5_t[a] <= r4_t[a];
            end
            r1_geom <= i_geom;

            r2_c    <= w_csum[F+CW-1:F];
            r2_rr   <= RRW'(r1_geom.ratio) * RRW'(r1_geom.ratio);
            r2_geom <= r1_geom;

            r3_ccp  <= r2_c * r2_c;
            r3_r2   <= w_rrs[RRS-1:F];
            r3_geom <= r2_geom;

            r4_omc  <= OMW'(ONE) - OMW'(w_cc);
            r4_r2   <= r3_r2;
            r4_geom <= r3_geom;

            r5_kp   <= w_r2s * r4_omc;
            r5_geom <= r4_geom;

            r6_rad  <= w_k[KW-1] ? '0 : SRW'({w_k[KW-2:0], {F{1'b0}}});
            r6_side.tir <= w_k[KW-1];
            for (int a = 0; a < AX; a++) begin
                r6_side.t[a] <= r5_t[a];
            end
            r6_side.geom <= r5_geom;
        end
    end

    vru_isqrt #(
        .RAD_W  (SRW),
        .SIDE_W ($bits(t_root_side))
    ) u_disc_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r6_vld),
        .i_rad   (r6_rad),
        .i_side  (r6_side),
        .o_valid (w_root_vld),
        .o_root  (w_sq),
        .o_side  (w_root_out)
    );

    always_comb begin
        w_rs  = {1'b0, w_root_out.geom.ratio};
        w_sqs = {1'b0, w_sq};
        for (int a = 0; a < AX; a++) begin
            w_fn[a] = $signed(w_root_out.geom.normal[a]);
            w_ft[a] = $signed(w_root_out.t[a]);
        end
    end

    // r*t - n*sqrt(k), then clamp to the output range
    always_comb begin
        for (int a = 0; a < AX; a++) begin
            w_rts[a] = RTS'(r7_rt[a]) + RTS'(HALF);
            w_nss[a] = NSS'(r7_nsq[a]) + NSS'(HALF);
            w_rtq[a] = w_rts[a][RTS-1:F];
            w_nsq[a] = w_nss[a][NSS-1:F];
            w_o[a]   = OCW'(w_rtq[a]) - OCW'(w_nsq[a]);
            n_clip[a] = 1'b0;
            if (w_o[a] > POS_LIM) begin
                n_refr[a] = POS_LIM[VW-1:0];
                n_clip[a] = 1'b1;
            end else if (w_o[a] < NEG_LIM) begin
                n_refr[a] = NEG_LIM[VW-1:0];
                n_clip[a] = 1'b1;
            end else begin
                n_refr[a] = w_o[a][VW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int a = 0; a < AX; a++) begin
                r7_rt[a]  <= w_rs * w_ft[a];
                r7_nsq[a] <= w_fn[a] * w_sqs;
            end
            r7_tir <= w_root_out.tir;

            if (r7_tir) begin
                r8_refr <= '0;
                r8_did  <= 1'b0;
                r8_sat  <= 1'b0;
            end else begin
                r8_refr <= n_refr;
                r8_did  <= 1'b1;
                r8_sat  <= |n_clip;
            end
        end
    end

    assign o_valid       = r8_vld;
    assign o_refr        = r8_refr;
    assign o_did_refract = r8_did;
    assign o_saturated   = r8_sat;

endmodule

>>> design/vector_refraction_unit.sv
// ----------------------------------------------------------------------------
// vector_refraction_unit
// Snell refraction of a 3D direction in signed fixed point.
// ----------------------------------------------------------------------------
// Takes one request per cycle while o_stall is low and returns one result per
// request, in order. The pipeline depth is set mostly by the two square root
// pipelines and the divider, which each resolve one bit per stage. The whole
// pipeline holds on output stall, and o_stall follows i_stall whenever a
// result waits.
module vector_refraction_unit #(
    parameter int FRAC_BITS = vru_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [vru_pkg::VEC_W-1:0]    i_incident_x,
    input  logic [vru_pkg::VEC_W-1:0]    i_incident_y,
    input  logic [vru_pkg::VEC_W-1:0]    i_incident_z,
    input  logic [vru_pkg::NRM_W-1:0]    i_normal_x,
    input  logic [vru_pkg::NRM_W-1:0]    i_normal_y,
    input  logic [vru_pkg::NRM_W-1:0]    i_normal_z,
    input  logic [vru_pkg::RATIO_W-1:0]  i_index_ratio,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [vru_pkg::VEC_W-1:0]    o_refracted_x,
    output logic [vru_pkg::VEC_W-1:0]    o_refracted_y,
    output logic [vru_pkg::VEC_W-1:0]    o_refracted_z,
    output logic                         o_did_refract,
    output logic                         o_saturated
);

    logic                                       w_adv;
    vru_pkg::t_vec                              w_vec;
    vru_pkg::t_geom                             w_geom;
    logic                                       w_norm_vld;
    logic [vru_pkg::AXES-1:0][FRAC_BITS+1:0]    w_unit;
    vru_pkg::t_geom                             w_norm_geom;
    vru_pkg::t_vec                              w_refr;

    // advance everything unless a finished result is being held
    assign w_adv   = ~o_valid | ~i_stall;
    assign o_stall = ~w_adv;

    assign w_vec[0]         = i_incident_x;
    assign w_vec[1]         = i_incident_y;
    assign w_vec[2]         = i_incident_z;
    assign w_geom.normal[0] = i_normal_x;
    assign w_geom.normal[1] = i_normal_y;
    assign w_geom.normal[2] = i_normal_z;
    assign w_geom.ratio     = i_index_ratio;

    vru_norm #(
        .FRAC_BITS (FRAC_BITS)
    ) u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (i_valid),
        .i_vec   (w_vec),
        .i_geom  (w_geom),
        .o_valid (w_norm_vld),
        .o_unit  (w_unit),
        .o_geom  (w_norm_geom)
    );

    vru_snell #(
        .FRAC_BITS (FRAC_BITS)
    ) u_snell (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_adv),
        .i_valid       (w_norm_vld),
        .i_unit        (w_unit),
        .i_geom        (w_norm_geom),
        .o_valid       (o_valid),
        .o_refr        (w_refr),
        .o_did_refract (o_did_refract),
        .o_saturated   (o_saturated)
    );

    assign o_refracted_x = w_refr[0];
    assign o_refracted_y = w_refr[1];
    assign o_refracted_z = w_refr[2];

    a_tir_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_did_refract) |->
            (o_refracted_x == '0 && o_refracted_y == '0 &&
             o_refracted_z == '0 && !o_saturated))
        else $error("reflected result carries a nonzero vector or clamp flag");

    a_sat_only_refract: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |-> o_did_refract)
        else $error("clamp flag set on a reflected result");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

>>> sim/tb_vector_refraction_unit.sv
// ----------------------------------------------------------------------------
// tb_vector_refraction_unit
// Self-checking bench for the vector refraction pipeline: a directed set of
// edge cases, then random rays, checked in order against a fixed-point model
// of normalization, discriminant and Snell refraction.
// ----------------------------------------------------------------------------
module tb_vector_refraction_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     FB       = vru_pkg::FRAC_BITS_DEF;
    localparam longint Q_ONE    = longint'(1) << FB;
    localparam int     TAIL_CYC = 200;

    typedef struct {
        logic [vru_pkg::VEC_W-1:0]   ix, iy, iz;
        logic [vru_pkg::NRM_W-1:0]   nx, ny, nz;
        logic [vru_pkg::RATIO_W-1:0] ratio;
    } t_ray;

    typedef struct {
        logic [vru_pkg::VEC_W-1:0] rx, ry, rz;
        logic                      did;
        logic                      sat;
    } t_refr;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_stall;
    logic [vru_pkg::VEC_W-1:0]     i_incident_x, i_incident_y, i_incident_z;
    logic [vru_pkg::NRM_W-1:0]     i_normal_x, i_normal_y, i_normal_z;
    logic [vru_pkg::RATIO_W-1:0]   i_index_ratio;
    logic                          o_valid;
    logic                          i_stall;
    logic [vru_pkg::VEC_W-1:0]     o_refracted_x, o_refracted_y, o_refracted_z;
    logic                          o_did_refract;
    logic                          o_saturated;

    t_refr pending_refr[$];
    int    mismatches;
    bit    gaps_on;
    bit    stall_on;
    int    stall_left;

    vector_refraction_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_incident_x  (i_incident_x),
        .i_incident_y  (i_incident_y),
        .i_incident_z  (i_incident_z),
        .i_normal_x    (i_normal_x),
        .i_normal_y    (i_normal_y),
        .i_normal_z    (i_normal_z),
        .i_index_ratio (i_index_ratio),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_refracted_x (o_refracted_x),
        .o_refracted_y (o_refracted_y),
        .o_refracted_z (o_refracted_z),
        .o_did_refract (o_did_refract),
        .o_saturated   (o_saturated)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // fixed-point refraction model
    // ------------------------------------------------------------------
    function automatic longint mul_round(longint a, longint b);
        return (a * b + (longint'(1) << (FB - 1))) >>> FB;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned x);
        longint unsigned root;
        longint unsigned cand;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            cand = root | (longint'(1) << b);
            if (cand * cand <= x)
                root = cand;
        end
        return root;
    endfunction

    function automatic t_refr predict_refraction(t_ray q);
        longint                    v[3], n[3], u[3];
        longint                    r, c, omc, r2, k, sq, t, o;
        longint unsigned           av[3], m, sum, len, quo;
        logic [vru_pkg::VEC_W-1:0] res[3];
        t_refr                     e;
        v[0] = $signed(q.ix);
        v[1] = $signed(q.iy);
        v[2] = $signed(q.iz);
        n[0] = $signed(q.nx);
        n[1] = $signed(q.ny);
        n[2] = $signed(q.nz);
        r = longint'(q.ratio);
        m = 0;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            av[i] = v[i] < 0 ? -v[i] : v[i];
            if (av[i] > m)
                m = av[i];
        end
        if (m == 0) begin
            for (int i = 0; i < 3; i++)
                u[i] = 0;
        end else begin
            while (m < (longint'(1) << 29)) begin
                m = m << 1;
                for (int i = 0; i < 3; i++)
                    av[i] = av[i] << 1;
            end
            for (int i = 0; i < 3; i++)
                sum += av[i] * av[i];
            len = root_floor(sum);
            for (int i = 0; i < 3; i++) begin
                quo = ((av[i] << FB) + (len >> 1)) / len;
                u[i] = v[i] < 0 ? -longint'(quo) : longint'(quo);
            end
        end
        c = 0;
        for (int i = 0; i < 3; i++)
            c += u[i] * n[i];
        c = (c + (longint'(1) << (FB - 1))) >>> FB;
        omc = Q_ONE - mul_round(c, c);
        r2 = mul_round(r, r);
        k = Q_ONE - mul_round(r2, omc);
        e.sat = 1'b0;
        if (k < 0) begin
            e.rx = '0;
            e.ry = '0;
            e.rz = '0;
            e.did = 1'b0;
            return e;
        end
        sq = longint'(root_floor(longint'(k) << FB));
        for (int i = 0; i < 3; i++) begin
            t = u[i] - mul_round(n[i], c);
            o = mul_round(r, t) - mul_round(n[i], sq);
            if (o > 64'sd2147483647) begin
                o = 64'sd2147483647;
                e.sat = 1'b1;
            end else if (o < -64'sd2147483648) begin
                o = -64'sd2147483648;
                e.sat = 1'b1;
            end
            res[i] = o[vru_pkg::VEC_W-1:0];
        end
        e.rx = res[0];
        e.ry = res[1];
        e.rz = res[2];
        e.did = 1'b1;
        return e;
    endfunction

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // called at a rising edge; returns at the edge that accepts the request
    task automatic send_ray(t_ray q);
        int gap;
        gap = 0;
        if (gaps_on && $urandom_range(0, 2) == 0)
            gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_incident_x  <= q.ix;
        i_incident_y  <= q.iy;
        i_incident_z  <= q.iz;
        i_normal_x    <= q.nx;
        i_normal_y    <= q.ny;
        i_normal_z    <= q.nz;
        i_index_ratio <= q.ratio;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        pending_refr.push_back(predict_refraction(q));
    endtask

    task automatic drain_pipe();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_refr.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic t_ray mk_ray(int ix, int iy, int iz, int nx, int ny, int nz,
                                    int ratio);
        t_ray q;
        q.ix = ix;
        q.iy = iy;
        q.iz = iz;
        q.nx = nx[vru_pkg::NRM_W-1:0];
        q.ny = ny[vru_pkg::NRM_W-1:0];
        q.nz = nz[vru_pkg::NRM_W-1:0];
        q.ratio = ratio[vru_pkg::RATIO_W-1:0];
        return q;
    endfunction

    function automatic logic [vru_pkg::VEC_W-1:0] rand_component();
        logic signed [vru_pkg::VEC_W-1:0] w;
        w = $urandom;
        return w >>> $urandom_range(0, 31);
    endfunction

    // unit normal in signed Q2.16 with random signs
    function automatic t_ray rand_wellformed();
        t_ray q;
        int   a, b, cz;
        a  = $urandom_range(0, 92680) - 46340;
        b  = $urandom_range(0, 92680) - 46340;
        cz = $rtoi($sqrt(4294967296.0 - real'(a) * a - real'(b) * b) + 0.5);
        if ($urandom_range(0, 1))
            cz = -cz;
        case ($urandom_range(0, 2))
            0: q = mk_ray(0, 0, 0, a, b, cz, 0);
            1: q = mk_ray(0, 0, 0, cz, a, b, 0);
            default: q = mk_ray(0, 0, 0, b, cz, a, 0);
        endcase
        q.ix = rand_component();
        q.iy = rand_component();
        q.iz = rand_component();
        q.ratio = $urandom_range(0, 3) == 0
                ? vru_pkg::RATIO_W'($urandom_range(0, 262144))
                : vru_pkg::RATIO_W'($urandom_range(32768, 131072));
        return q;
    endfunction

    function automatic t_ray rand_noise();
        t_ray q;
        q.ix = $urandom;
        q.iy = $urandom;
        q.iz = $urandom;
        q.nx = vru_pkg::NRM_W'($urandom);
        q.ny = vru_pkg::NRM_W'($urandom);
        q.nz = vru_pkg::NRM_W'($urandom);
        q.ratio = vru_pkg::RATIO_W'($urandom);
        return q;
    endfunction

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || !stall_on) begin
            i_stall <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else begin
            i_stall <= 1'b0;
            if ($urandom_range(0, 7) == 0)
                stall_left <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        t_refr e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_refr.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result x=%h y=%h z=%h", o_refracted_x,
                             o_refracted_y, o_refracted_z);
            end else begin
                e = pending_refr.pop_front();
                if (o_refracted_x !== e.rx || o_refracted_y !== e.ry ||
                    o_refracted_z !== e.rz || o_did_refract !== e.did ||
                    o_saturated !== e.sat) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp x=%h y=%h z=%h ref=%b sat=%b",
                                 e.rx, e.ry, e.rz, e.did, e.sat,
                                 " got x=%h y=%h z=%h ref=%b sat=%b",
                                 o_refracted_x, o_refracted_y, o_refracted_z,
                                 o_did_refract, o_saturated);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_edge_cases();
        // zero incident vector passes through; k = 1 - r^2
        send_ray(mk_ray(0, 0, 0, 0, 0, 65536, 65536));
        send_ray(mk_ray(0, 0, 0, 0, 0, 65536, 262144));
        // straight-on incidence
        send_ray(mk_ray(0, 0, -65536, 0, 0, 65536, 65536));
        send_ray(mk_ray(0, 0, -65536, 0, 0, 65536, 43690));
        // grazing ray beyond the critical angle
        send_ray(mk_ray(65536, 0, 0, 0, 65536, 0, 131072));
        send_ray(mk_ray(65536, -100, 0, 0, 65536, 0, 262144));
        // zero ratio
        send_ray(mk_ray(1000, 2000, -3000, 0, 0, 65536, 0));
        // field extremes
        send_ray(mk_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 65536, 0, 0, 65536));
        send_ray(mk_ray(32'h80000000, 32'h80000000, 32'h80000000, -65536, 0, 0, 65536));
        send_ray(mk_ray(32'h80000000, 32'h7fffffff, 1, 0, -65536, 0, 262144));
        send_ray(mk_ray(1, 0, 0, -65536, 0, 0, 65536));
        send_ray(mk_ray(-1, -1, 0, 0, 0, -65536, 32768));
        // normal beyond unit length
        send_ray(mk_ray(5000, -7000, 9000, 131071, 131071, 131071, 65536));
        send_ray(mk_ray(5000, -7000, 9000, -131072, -131072, -131072, 524287));
        send_ray(mk_ray(-5000, 7000, -9000, 131071, -131072, 65536, 524287));
        // ratio above 4.0
        send_ray(mk_ray(0, 0, 0, 0, 0, 0, 524287));
        send_ray(mk_ray(0, 65536, 65536, 0, 0, -65536, 300000));
    endtask

    task automatic test_wellformed_rays(int count);
        for (int i = 0; i < count; i++)
            send_ray(rand_wellformed());
    endtask

    task automatic test_noise_rays(int count);
        for (int i = 0; i < count; i++)
            send_ray(rand_noise());
    endtask

    task automatic test_back_to_back(int count);
        gaps_on = 1'b0;
        stall_on = 1'b0;
        for (int i = 0; i < count; i++)
            send_ray($urandom_range(0, 1) ? rand_wellformed() : rand_noise());
        gaps_on = 1'b1;
        stall_on = 1'b1;
    endtask

    initial begin
        mismatches = 0;
        gaps_on = 1'b1;
        stall_on = 1'b1;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_incident_x  <= '0;
        i_incident_y  <= '0;
        i_incident_z  <= '0;
        i_normal_x    <= '0;
        i_normal_y    <= '0;
        i_normal_z    <= '0;
        i_index_ratio <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_edge_cases();
        test_wellformed_rays(700);
        // hold off until the pipeline is empty
        drain_pipe();
        test_back_to_back(200);
        test_noise_rays(400);
        test_wellformed_rays(400);

        drain_pipe();
        repeat (TAIL_CYC) @(posedge i_clk);
        if (mismatches == 0 && pending_refr.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
